[sv/lphp_pkg.sv]
// Package with types and constants of the loader packet header parser.
`default_nettype none
package lphp_pkg;

  localparam int unsigned HDR_LEN = 9;

  localparam logic [7:0] CMD_READ   = 8'd0;
  localparam logic [7:0] CMD_WRITE  = 8'd1;
  localparam logic [7:0] CMD_ERASE  = 8'd2;
  localparam logic [7:0] CMD_UNLOAD = 8'd3;
  localparam logic [7:0] CMD_LOAD   = 8'd4;

  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_UNSUPPORTED = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] body_index;
    logic [7:0]  body_byte;
    logic [7:0]  command_code;
    logic [31:0] page_address;
    logic [15:0] page_words;
    logic        status;
    logic        last;
  } result_t;

  function automatic logic cmd_status(input logic [7:0] cmd, input logic had_body);
    logic ok;
    if (had_body) begin
      ok = (cmd == CMD_WRITE);
    end else begin
      ok = (cmd == CMD_READ) || (cmd == CMD_ERASE) || (cmd == CMD_UNLOAD) ||
           (cmd == CMD_LOAD);
    end
    return ok ? STATUS_OK : STATUS_UNSUPPORTED;
  endfunction

endpackage
`default_nettype wire

[sv/loader_packet_header_parser_top.sv]
// Top level of the loader packet header parser: header collection, body count, result queue.
// Results are registered in the result queue when their byte is taken and leave it in order.
// Throughput: one byte per cycle while in_tready is high; a packet's final body byte yields
// two words, drained one per cycle while out_tready is high from a three-entry result queue.
// in_tready is high while the queue holds at most one word.
// Reset (rst_n low, synchronous) clears the parser to header collection and empties the queue.
`default_nettype none
module loader_packet_header_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // [15:0] body_index, [23:16] body_byte,
                                       // [31:24] command_code, [63:32] page_address,
                                       // [79:64] page_words, [80] status, [87:81] zero
  output logic             out_tuser,  // [0] kind
  output logic             out_tlast   // last
);

  localparam logic [3:0]  HDR_LAST = 4'(lphp_pkg::HDR_LEN - 1);
  localparam logic [15:0] HDR_LEN16 = 16'(lphp_pkg::HDR_LEN);

  logic              in_body_r, in_body_nxt;
  logic [3:0]        hcount_r, hcount_nxt;
  logic [7:0]        hdr_r [lphp_pkg::HDR_LEN];
  logic [15:0]       remain_r, remain_nxt;
  logic [15:0]       bcount_r, bcount_nxt;

  lphp_pkg::result_t q_r [3];
  logic [1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  logic              in_acc, out_acc;
  logic              push0, push1;
  lphp_pkg::result_t res0, res1;
  logic [15:0]       len;
  logic [15:0]       remain_dec;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign in_tready = (count_r <= 2'd1);
  assign in_acc    = in_tvalid & in_tready;
  assign out_tvalid = (count_r != 2'd0);
  assign out_acc   = out_tvalid & out_tready;

  assign len        = {hdr_r[2], hdr_r[1]};
  assign remain_dec = remain_r - 16'd1;

  always_comb begin
    in_body_nxt = in_body_r;
    hcount_nxt  = hcount_r;
    remain_nxt  = remain_r;
    bcount_nxt  = bcount_r;
    push0       = 1'b0;
    push1       = 1'b0;
    res0        = '0;
    res1        = '0;
    if (in_acc) begin
      if (!in_body_r) begin
        hcount_nxt = hcount_r + 4'd1;
        if (hcount_r == HDR_LAST) begin
          hcount_nxt = 4'd0;
          bcount_nxt = 16'd0;
          remain_nxt = (len < HDR_LEN16) ? 16'd0 : len - HDR_LEN16;
          if (remain_nxt != 16'd0) begin
            in_body_nxt = 1'b1;
          end else begin
            push0              = 1'b1;
            res0.kind          = lphp_pkg::KIND_COMMAND;
            res0.command_code  = hdr_r[0];
            res0.page_address  = {hdr_r[6], hdr_r[5], hdr_r[4], hdr_r[3]};
            res0.page_words    = {in_tdata, hdr_r[7]};
            res0.status        = lphp_pkg::cmd_status(hdr_r[0], 1'b0);
            res0.last          = 1'b1;
          end
        end
      end else begin
        remain_nxt      = remain_dec;
        push0           = 1'b1;
        res0.kind       = lphp_pkg::KIND_BODY;
        res0.body_index = bcount_r;
        res0.body_byte  = in_tdata;
        if (remain_dec != 16'd0) begin
          res0.last  = 1'b1;
          bcount_nxt = bcount_r + 16'd1;
        end else begin
          res0.last          = 1'b0;
          push1              = 1'b1;
          res1.kind          = lphp_pkg::KIND_COMMAND;
          res1.command_code  = hdr_r[0];
          res1.page_address  = {hdr_r[6], hdr_r[5], hdr_r[4], hdr_r[3]};
          res1.page_words    = {hdr_r[8], hdr_r[7]};
          res1.status        = lphp_pkg::cmd_status(hdr_r[0], 1'b1);
          res1.last          = 1'b1;
          in_body_nxt        = 1'b0;
          bcount_nxt         = 16'd0;
        end
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push1) begin
      wr_ptr_nxt = inc3(inc3(wr_ptr_r));
    end else if (push0) begin
      wr_ptr_nxt = inc3(wr_ptr_r);
    end
    rd_ptr_nxt = out_acc ? inc3(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push0} + {1'b0, push1} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
      hcount_r  <= 4'd0;
      remain_r  <= 16'd0;
      bcount_r  <= 16'd0;
      wr_ptr_r  <= 2'd0;
      rd_ptr_r  <= 2'd0;
      count_r   <= 2'd0;
    end else begin
      in_body_r <= in_body_nxt;
      hcount_r  <= hcount_nxt;
      remain_r  <= remain_nxt;
      bcount_r  <= bcount_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lphp_pkg::HDR_LEN; i++) begin
        hdr_r[i] <= 8'd0;
      end
    end else if (in_acc && !in_body_r) begin
      hdr_r[hcount_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push1) begin
      q_r[inc3(wr_ptr_r)] <= res1;
    end
  end

  assign out_tdata = {7'd0, q_r[rd_ptr_r].status, q_r[rd_ptr_r].page_words,
                      q_r[rd_ptr_r].page_address, q_r[rd_ptr_r].command_code,
                      q_r[rd_ptr_r].body_byte, q_r[rd_ptr_r].body_index};
  assign out_tuser = q_r[rd_ptr_r].kind;
  assign out_tlast = q_r[rd_ptr_r].last;

endmodule
`default_nettype wire

[bench/loader_parser_checker.sv]
// Checker for the loader packet header parser: predicts result words and compares them.
module loader_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  logic [7:0]          hdr [lphp_pkg::HDR_LEN];
  logic [3:0]          hdr_fill;
  logic                in_body_q;
  logic [15:0]         body_left;
  logic [15:0]         body_pos;
  lphp_pkg::result_t   expected_words[$];

  function automatic logic command_verdict(input logic [7:0] cmd, input logic had_body);
    if (had_body) begin
      return (cmd == lphp_pkg::CMD_WRITE) ? lphp_pkg::STATUS_OK : lphp_pkg::STATUS_UNSUPPORTED;
    end
    case (cmd)
      lphp_pkg::CMD_READ, lphp_pkg::CMD_ERASE, lphp_pkg::CMD_UNLOAD,
      lphp_pkg::CMD_LOAD: return lphp_pkg::STATUS_OK;
      default: return lphp_pkg::STATUS_UNSUPPORTED;
    endcase
  endfunction

  function automatic string show(input lphp_pkg::result_t r);
    return $sformatf("kind=%0d idx=%h byte=%h cmd=%h addr=%h words=%h status=%0d last=%0d",
                     r.kind, r.body_index, r.body_byte, r.command_code, r.page_address,
                     r.page_words, r.status, r.last);
  endfunction

  task automatic push_command(input logic had_body);
    lphp_pkg::result_t r;
    r = '0;
    r.kind         = lphp_pkg::KIND_COMMAND;
    r.command_code = hdr[0];
    r.page_address = {hdr[6], hdr[5], hdr[4], hdr[3]};
    r.page_words   = {hdr[8], hdr[7]};
    r.status       = command_verdict(hdr[0], had_body);
    r.last         = 1'b1;
    expected_words.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] d);
    logic [15:0]       total;
    lphp_pkg::result_t r;
    if (!in_body_q) begin
      hdr[hdr_fill] = d;
      if (hdr_fill != 4'(lphp_pkg::HDR_LEN - 1)) begin
        hdr_fill = hdr_fill + 4'd1;
      end else begin
        hdr_fill = '0;
        total = {hdr[2], hdr[1]};
        if (total < 16'(lphp_pkg::HDR_LEN)) total = 16'(lphp_pkg::HDR_LEN);
        body_left = total - 16'(lphp_pkg::HDR_LEN);
        body_pos  = '0;
        if (body_left != 0) in_body_q = 1'b1;
        else push_command(1'b0);
      end
    end else begin
      body_left    = body_left - 16'd1;
      r            = '0;
      r.kind       = lphp_pkg::KIND_BODY;
      r.body_index = body_pos;
      r.body_byte  = d;
      r.last       = (body_left != 0);
      expected_words.push_back(r);
      if (body_left != 0) begin
        body_pos = body_pos + 16'd1;
      end else begin
        push_command(1'b1);
        in_body_q = 1'b0;
        body_pos  = '0;
      end
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count = fail_count + 1;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    lphp_pkg::result_t got;
    lphp_pkg::result_t want;
    if (!rst_n) begin
      foreach (hdr[i]) hdr[i] = '0;
      hdr_fill   = '0;
      in_body_q  = 1'b0;
      body_left  = '0;
      body_pos   = '0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got              = '0;
        got.kind         = out_tuser;
        got.body_index   = out_tdata[15:0];
        got.body_byte    = out_tdata[23:16];
        got.command_code = out_tdata[31:24];
        got.page_address = out_tdata[63:32];
        got.page_words   = out_tdata[79:64];
        got.status       = out_tdata[80];
        got.last         = out_tlast;
        if (expected_words.size() == 0) begin
          note_failure({"unexpected word ", show(got)});
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            note_failure({"expected ", show(want), " got ", show(got)});
          end
        end
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata);
    end
    pending = expected_words.size();
  end

endmodule

[bench/loader_packet_header_parser_top_test.sv]
// Testbench top for the loader packet header parser: clock, reset, stimulus and verdict.
module loader_packet_header_parser_top_test;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 1650;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          sent_bytes;
  int          stall_cycles;
  bit          quiet;
  bit          hold_req;

  loader_packet_header_parser_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  loader_parser_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sent_bytes = sent_bytes + 1;
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] cmd, input logic [15:0] len,
                             input logic [31:0] addr, input logic [15:0] words);
    int nbody;
    nbody = (len < 16'(lphp_pkg::HDR_LEN)) ? 0 : int'(len) - int'(lphp_pkg::HDR_LEN);
    send_byte(cmd);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(addr[7:0]);
    send_byte(addr[15:8]);
    send_byte(addr[23:16]);
    send_byte(addr[31:24]);
    send_byte(words[7:0]);
    send_byte(words[15:8]);
    for (int i = 0; i < nbody; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int          pkt;
    int          pick;
    logic [7:0]  cmd;
    logic [15:0] len;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    sent_bytes = 0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_packet(lphp_pkg::CMD_READ, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(lphp_pkg::CMD_WRITE, 16'd11, 32'h0000_0000, 16'h0000);
    send_packet(8'hFF, 16'd9, 32'h8000_0001, 16'h8001);

    pkt = 0;
    while (sent_bytes < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      cmd  = (pick < 85) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick < 4) len = 16'($urandom_range(0, 9));
      else if (pick < 9) len = 16'(lphp_pkg::HDR_LEN + $urandom_range(1, 24));
      else len = 16'(lphp_pkg::HDR_LEN + $urandom_range(25, 120));
      if (cmd == lphp_pkg::CMD_WRITE && $urandom_range(0, 99) < 70) begin
        len = 16'(lphp_pkg::HDR_LEN + $urandom_range(1, 30));
      end
      if ($urandom_range(0, 99) < 8) begin
        cmd = 8'($urandom_range(0, 255));
        len = 16'($urandom_range(0, 255));
      end
      if (pkt == 15) hold_req = 1'b1;
      if (pkt == 30) begin
        in_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (5) @(negedge clk);
      end
      quiet = (pkt >= 50 && pkt < 80);
      send_packet(cmd, len, $urandom, 16'($urandom_range(0, 65535)));
      pkt = pkt + 1;
    end

    in_tvalid <= 1'b0;
    quiet = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
